>>> sv/crc16fv_pkg.sv
// Shared types, constants and the byte-wide CRC-16 update for the frame validator.
package crc16fv_pkg;

    // Frame layout
    localparam int unsigned FRAME_OVERHEAD = 7;
    localparam int unsigned POSITION_LIMIT = 263;
    localparam int unsigned POS_WIDTH      = 9;
    localparam int unsigned CMP_WIDTH      = 10;

    // Register reset values
    localparam logic [7:0]  PREAMBLE_RESET = 8'hAA;
    localparam logic [15:0] SEED_RESET     = 16'hFFFF;
    localparam logic [15:0] POLY_RESET     = 16'hA001;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PREAMBLE = 2'd0,
        REG_SEED     = 2'd1,
        REG_POLY     = 2'd2
    } reg_index_t;

    // Check result codes
    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_UNDER_MIN = 3'd1,
        STATUS_PREAMBLE  = 3'd2,
        STATUS_TRUNCATED = 3'd3,
        STATUS_CRC       = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  preamble_value;
        logic [15:0] crc_seed;
        logic [15:0] crc_polynomial;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } item_t;

    // Reflected CRC-16 over one byte, eight bit steps unrolled
    function automatic logic [15:0] crc16fv_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b,
                                                 input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> sv/crc16fv_cfg_regs.sv
// Configuration register file: preamble, CRC seed and CRC polynomial.
module crc16fv_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output crc16fv_pkg::cfg_t  cfg
);
    import crc16fv_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take writes
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_PREAMBLE: cfg_next.preamble_value = cfg_data[7:0];
                REG_SEED:     cfg_next.crc_seed       = cfg_data;
                REG_POLY:     cfg_next.crc_polynomial = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.preamble_value <= PREAMBLE_RESET;
            cfg_reg.crc_seed       <= SEED_RESET;
            cfg_reg.crc_polynomial <= POLY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> sv/crc16fv_frame_check.sv
// Per-byte frame tracking, CRC accumulation and the registered check result.
module crc16fv_frame_check (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  crc16fv_pkg::cfg_t     cfg,
    input  logic                  item_valid,
    input  crc16fv_pkg::item_t    item,
    output logic                  item_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  res_frame_ok,
    output crc16fv_pkg::status_t  res_status
);
    import crc16fv_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_LIMIT  = POS_WIDTH'(POSITION_LIMIT);
    localparam logic [POS_WIDTH-1:0] POS_LENGTH = POS_WIDTH'(2);
    localparam logic [CMP_WIDTH-1:0] CRC_LAST   = CMP_WIDTH'(4);
    localparam logic [CMP_WIDTH-1:0] RX_HIGH    = CMP_WIDTH'(5);
    localparam logic [CMP_WIDTH-1:0] RX_LOW     = CMP_WIDTH'(6);
    localparam logic [CMP_WIDTH-1:0] OVERHEAD   = CMP_WIDTH'(FRAME_OVERHEAD);

    logic [POS_WIDTH-1:0] pos_reg,   pos_next;
    logic [15:0]          crc_reg,   crc_next;
    logic [7:0]           len_reg,   len_next;
    logic                 match_reg, match_next;
    logic [15:0]          rx_reg,    rx_next;
    logic                 valid_reg, valid_next;
    status_t              status_reg, status_next;

    logic                 take;
    logic [7:0]           plen;
    logic [CMP_WIDTH-1:0] plen_ext;
    logic [CMP_WIDTH-1:0] pos_ext;
    logic [CMP_WIDTH-1:0] count;

    // Advance when the result register is empty or being drained
    assign item_ready = !valid_reg || res_ready;
    assign take       = item_valid && item_ready;

    assign plen     = (pos_reg == POS_LENGTH) ? item.data_byte : len_reg;
    assign plen_ext = {2'b00, plen};
    assign pos_ext  = {1'b0, pos_reg};
    assign count    = pos_ext + CMP_WIDTH'(1);

    // Frame state update for one byte
    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        len_next    = len_reg;
        match_next  = match_reg;
        rx_next     = rx_reg;
        valid_next  = valid_reg && !res_ready;
        status_next = status_reg;
        if (take) begin
            if (pos_reg == '0) begin
                match_next = (item.data_byte == cfg.preamble_value);
                crc_next   = cfg.crc_seed;
            end else begin
                len_next = plen;
                if (pos_ext <= CRC_LAST + plen_ext) begin
                    crc_next = crc16fv_byte(crc_reg, item.data_byte, cfg.crc_polynomial);
                end else if (pos_ext == RX_HIGH + plen_ext) begin
                    rx_next = {item.data_byte, rx_reg[7:0]};
                end else if (pos_ext == RX_LOW + plen_ext) begin
                    rx_next = {rx_reg[15:8], item.data_byte};
                end
            end
            if (pos_reg < POS_LIMIT) begin
                pos_next = pos_reg + POS_WIDTH'(1);
            end
            // Last byte: report the first failing check, then clear the frame
            if (item.buffer_end) begin
                valid_next = 1'b1;
                if (count < OVERHEAD) begin
                    status_next = STATUS_UNDER_MIN;
                end else if (!match_next) begin
                    status_next = STATUS_PREAMBLE;
                end else if (count < OVERHEAD + plen_ext) begin
                    status_next = STATUS_TRUNCATED;
                end else if (crc_next != rx_next) begin
                    status_next = STATUS_CRC;
                end else begin
                    status_next = STATUS_OK;
                end
                pos_next   = '0;
                crc_next   = '0;
                len_next   = '0;
                match_next = 1'b0;
                rx_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            crc_reg    <= '0;
            len_reg    <= '0;
            match_reg  <= 1'b0;
            rx_reg     <= '0;
            valid_reg  <= 1'b0;
            status_reg <= STATUS_OK;
        end else begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            len_reg    <= len_next;
            match_reg  <= match_next;
            rx_reg     <= rx_next;
            valid_reg  <= valid_next;
            status_reg <= status_next;
        end
    end

    assign res_valid    = valid_reg;
    assign res_status   = status_reg;
    assign res_frame_ok = (status_reg == STATUS_OK);

`ifndef ASSERT_OFF
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LIMIT)
        else $error("byte position beyond saturation limit");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && item.buffer_end) |=> (pos_reg == '0 && !match_reg && crc_reg == '0))
        else $error("frame state not cleared after last byte");

    a_pos_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !item.buffer_end && pos_reg < POS_LIMIT)
        |=> (pos_reg == $past(pos_reg) + POS_WIDTH'(1)))
        else $error("byte position did not advance");

    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(valid_reg) |-> $past(take && item.buffer_end))
        else $error("result appeared without a last byte");
`endif

endmodule

>>> sv/crc16_frame_validator_unit.sv
// Top level of the CRC-16 frame validator: input register, frame check, config registers.
//
// Checks a received buffer streamed in one byte per item, s_tlast on the buffer's last
// byte. Byte 0 must match the preamble register, byte 2 gives the payload length P,
// and a reflected CRC-16 over bytes 1 to 4+P is compared with the next two bytes,
// high byte first; bytes past the frame are ignored. One result item leaves on m_
// for each buffer, carrying frame_ok and the status code (0 ok, 1 under 7 bytes,
// 2 bad preamble, 3 truncated, 4 CRC mismatch). The block takes one byte every
// cycle as long as no result is held up on m_; while a result waits for m_tready,
// the check stage stalls, and s_tready drops once the input register holds a byte.
// A result is presented once its last byte has passed from the input register through
// the check stage, whose byte-wide unrolled CRC update loads the result register; a
// result still waiting for m_tready holds it back. Write configuration only while no
// buffer is in flight.
module crc16_frame_validator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // buffer_end
    // Check results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] frame_ok, [3:1] check_status, [7:4] zero
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import crc16fv_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg, in_item_next;
    logic    in_valid_reg, in_valid_next;
    logic    chk_ready;
    logic    res_frame_ok;
    status_t res_status;

    crc16fv_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: load when empty or when the check stage takes the held item
    assign s_tready = !in_valid_reg || chk_ready;

    always_comb begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg && !chk_ready;
        if (s_tvalid && s_tready) begin
            in_item_next.data_byte  = s_tdata;
            in_item_next.buffer_end = s_tlast;
            in_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        in_item_reg <= in_item_next;
    end

    crc16fv_frame_check u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .item_valid   (in_valid_reg),
        .item         (in_item_reg),
        .item_ready   (chk_ready),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_frame_ok (res_frame_ok),
        .res_status   (res_status)
    );

    assign m_tdata = {4'b0000, res_status, res_frame_ok};

endmodule

>>> sim/testbench.sv
// Self-checking bench for the CRC-16 frame validator: framed byte streams against a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import crc16fv_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          ITEM_TARGET   = 730;
    localparam int          RESULT_TARGET = 40;
    localparam int          PHASE_ITEMS   = 100;
    localparam int          SETTLE_CYCLES = 4;
    localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

    typedef struct {
        logic    frame_ok;
        status_t status;
    } verdict_t;

    typedef enum {
        KIND_GOOD,
        KIND_BAD_CRC,
        KIND_BAD_PREAMBLE,
        KIND_TRUNCATED,
        KIND_SHORT,
        KIND_LONG,
        KIND_NOISE
    } buffer_kind_t;

    // Tracks frame state byte by byte and holds the verdicts still to come
    class crc_frame_checker;
        logic [7:0]  preamble_cfg;
        logic [15:0] seed_cfg;
        logic [15:0] poly_cfg;
        int          position;
        logic [15:0] crc_acc;
        logic [7:0]  payload_len;
        bit          preamble_hit;
        logic [15:0] crc_rx;
        verdict_t    verdicts_due[$];
        int          failures;
        int          verdicts_seen;

        function new();
            preamble_cfg  = PREAMBLE_RESET;
            seed_cfg      = SEED_RESET;
            poly_cfg      = POLY_RESET;
            failures      = 0;
            verdicts_seen = 0;
            restart();
        endfunction

        function void restart();
            position     = 0;
            crc_acc      = 16'h0000;
            payload_len  = 8'h00;
            preamble_hit = 1'b0;
            crc_rx       = 16'h0000;
        endfunction

        // One byte through the reflected CRC, LSB first
        function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
            logic [15:0] acc;
            bit          lsb;
            acc = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++) begin
                lsb = acc[0];
                acc = {1'b0, acc[15:1]};
                if (lsb) begin
                    acc = acc ^ poly_cfg;
                end
            end
            return acc;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [15:0] val);
            case (idx)
                REG_PREAMBLE: preamble_cfg = val[7:0];
                REG_SEED:     seed_cfg     = val;
                REG_POLY:     poly_cfg     = val;
                default:      ;
            endcase
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction

        // Advance the frame state; queue a verdict on the buffer's last byte
        function void note_byte(input logic [7:0] b, input bit last);
            int       p;
            int       plen;
            int       count;
            verdict_t v;
            p    = position;
            plen = payload_len;
            if (p == 0) begin
                preamble_hit = (b == preamble_cfg);
                crc_acc      = seed_cfg;
            end else begin
                if (p == 2) begin
                    payload_len = b;
                    plen        = b;
                end
                if (p <= 4 + plen) begin
                    crc_acc = crc_step(crc_acc, b);
                end else if (p == 5 + plen) begin
                    crc_rx[15:8] = b;
                end else if (p == 6 + plen) begin
                    crc_rx[7:0] = b;
                end
            end
            count = p + 1;
            if (position < POSITION_LIMIT) begin
                position++;
            end
            if (!last) begin
                return;
            end
            if (count < FRAME_OVERHEAD) begin
                v.status = STATUS_UNDER_MIN;
            end else if (!preamble_hit) begin
                v.status = STATUS_PREAMBLE;
            end else if (count < FRAME_OVERHEAD + plen) begin
                v.status = STATUS_TRUNCATED;
            end else if (crc_acc != crc_rx) begin
                v.status = STATUS_CRC;
            end else begin
                v.status = STATUS_OK;
            end
            v.frame_ok = (v.status == STATUS_OK);
            verdicts_due.push_back(v);
            restart();
        endfunction

        // Compare one result item with the oldest verdict due
        function void check_verdict(input logic [7:0] word);
            verdict_t v;
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
                $display("%0t: result item with nothing due, expected none, actual %h",
                         $time, word);
                failures++;
                return;
            end
            v = verdicts_due.pop_front();
            if (word[0] !== v.frame_ok) begin
                $display("%0t: frame_ok expected %0d actual %0d", $time, v.frame_ok, word[0]);
                failures++;
            end
            if (word[3:1] !== v.status) begin
                $display("%0t: check_status expected %0d actual %0d",
                         $time, v.status, word[3:1]);
                failures++;
            end
            if (word[7:4] !== 4'h0) begin
                $display("%0t: tdata padding expected 0 actual %h", $time, word[7:4]);
                failures++;
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data  = 16'h0000;

    crc_frame_checker tracker;
    logic [7:0]       frame_bytes[$];
    int               items_sent    = 0;
    int               buffers_sent  = 0;
    bit               tx_quiet      = 1'b0;
    int               cycle_count   = 0;
    int               stall_left    = 0;
    bit               rx_quiet      = 1'b0;
    int               rx_cycles     = 0;

    crc16_frame_validator_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [7:0] data_byte
        .s_tlast   (s_tlast),   // buffer_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [0] frame_ok, [3:1] check_status, [7:4] zero
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle(input bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Accept result items and stall the result side at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_verdict(m_tdata);
        end
        rx_cycles++;
        if (rx_cycles % 64 == 0) begin
            rx_quiet = ($urandom_range(0, 3) == 0);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_idle(rx_quiet);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Send the bytes in frame_bytes as one buffer, tlast on the final one
    task automatic send_buffer();
        int gap;
        bit last;
        for (int i = 0; i < frame_bytes.size(); i++) begin
            gap  = pick_idle(tx_quiet);
            last = (i == frame_bytes.size() - 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_bytes[i];
            s_tlast  <= last;
            do @(posedge aclk); while (!s_tready);
            tracker.note_byte(frame_bytes[i], last);
            items_sent++;
        end
        buffers_sent++;
    endtask

    // Hold off input until every verdict is in and the pipeline has drained
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, val);
    endtask

    task automatic program_registers(input logic [7:0] pre, input logic [15:0] seed,
                                     input logic [15:0] poly, input bit touch_unmapped);
        write_reg(REG_PREAMBLE, {8'($urandom_range(0, 255)), pre});
        write_reg(REG_SEED, seed);
        write_reg(REG_POLY, poly);
        if (touch_unmapped) begin
            write_reg(REG_UNMAPPED, 16'($urandom_range(0, 65535)));
        end
        cfg_valid <= 1'b0;
    endtask

    // Close a frame with its CRC over bytes 1 onward, optionally corrupted
    task automatic append_crc(input logic [15:0] flip);
        logic [15:0] crc;
        crc = tracker.seed_cfg;
        for (int i = 1; i < frame_bytes.size(); i++) begin
            crc = tracker.crc_step(crc, frame_bytes[i]);
        end
        crc = crc ^ flip;
        frame_bytes.push_back(crc[15:8]);
        frame_bytes.push_back(crc[7:0]);
    endtask

    // Build one buffer of the given kind under the current register settings
    task automatic build_buffer(input buffer_kind_t kind, input int plen, input int extra);
        logic [7:0] pre;
        int         n;
        int         keep;
        frame_bytes.delete();
        pre = tracker.preamble_cfg;
        if (kind == KIND_NOISE) begin
            n = $urandom_range(1, 20);
            repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (kind == KIND_SHORT) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                if (i == 0 && $urandom_range(0, 1) == 1) begin
                    frame_bytes.push_back(pre);
                end else begin
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            return;
        end
        if (kind == KIND_TRUNCATED && plen == 0) begin
            plen = 1;
        end
        if (kind == KIND_BAD_PREAMBLE) begin
            frame_bytes.push_back(pre ^ 8'($urandom_range(1, 255)));
        end else begin
            frame_bytes.push_back(pre);
        end
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'(plen));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (plen) frame_bytes.push_back(8'($urandom_range(0, 255)));
        append_crc(kind == KIND_BAD_CRC ? 16'($urandom_range(1, 65535)) : 16'h0000);
        if (kind == KIND_TRUNCATED) begin
            keep = $urandom_range(7, 6 + plen);
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        end
        if (kind == KIND_LONG) begin
            repeat (extra) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Stimulus
    initial begin
        int           phase;
        int           phase_start;
        int           roll;
        int           plen;
        int           extra;
        buffer_kind_t kind;
        logic [7:0]   pre;
        logic [15:0]  seed;
        logic [15:0]  poly;

        tracker = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one-byte buffer with a wrong first byte
        frame_bytes = {8'hFF};
        send_buffer();
        // Good minimal frame, zero payload
        frame_bytes = {PREAMBLE_RESET, 8'h00, 8'h00, 8'hFF, 8'hFF};
        append_crc(16'h0000);
        send_buffer();
        // Wrong preamble on a full frame
        frame_bytes = {8'h55, 8'hFF, 8'h00, 8'h01, 8'h80};
        append_crc(16'h0000);
        send_buffer();
        // Seven bytes but the length byte asks for more
        frame_bytes = {PREAMBLE_RESET, 8'h01, 8'h03, 8'h02, 8'h03, 8'h11, 8'h22};
        send_buffer();
        // CRC off by its top bit
        frame_bytes = {PREAMBLE_RESET, 8'h12, 8'h00, 8'h34, 8'h56};
        append_crc(16'h8000);
        send_buffer();

        // Random phases, registers rewritten between them
        phase = 0;
        while (items_sent < ITEM_TARGET || tracker.verdicts_seen < RESULT_TARGET) begin
            wait_idle();
            case (phase)
                0: begin
                    pre = PREAMBLE_RESET; seed = SEED_RESET; poly = POLY_RESET;
                end
                1: begin
                    pre = 8'h00; seed = 16'h0000; poly = 16'h0000;
                end
                2: begin
                    pre = 8'hFF; seed = 16'hFFFF; poly = 16'hFFFF;
                end
                3: begin
                    pre = 8'h55; seed = 16'h1D0F; poly = 16'h8408;
                end
                default: begin
                    pre  = 8'($urandom_range(0, 255));
                    seed = 16'($urandom_range(0, 65535));
                    poly = 16'($urandom_range(0, 65535));
                end
            endcase
            program_registers(pre, seed, poly, phase == 0);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                roll     = $urandom_range(0, 99);
                if (roll < 45) begin
                    kind = KIND_GOOD;
                end else if (roll < 55) begin
                    kind = KIND_BAD_CRC;
                end else if (roll < 65) begin
                    kind = KIND_BAD_PREAMBLE;
                end else if (roll < 75) begin
                    kind = KIND_TRUNCATED;
                end else if (roll < 83) begin
                    kind = KIND_SHORT;
                end else if (roll < 93) begin
                    kind = KIND_LONG;
                end else begin
                    kind = KIND_NOISE;
                end
                // Mostly small payloads, rarely large ones
                if ($urandom_range(0, 39) == 0) begin
                    plen = ($urandom_range(0, 1) == 1) ? 255 : $urandom_range(13, 255);
                end else begin
                    plen = $urandom_range(0, 12);
                end
                extra = $urandom_range(1, 8);
                // Force a full-length payload and a buffer past the position limit
                if (buffers_sent == 7) begin
                    kind = KIND_GOOD;
                    plen = 255;
                end else if (buffers_sent == 10) begin
                    kind  = KIND_LONG;
                    plen  = 3;
                    extra = 262;
                end
                build_buffer(kind, plen, extra);
                send_buffer();
                if ($urandom_range(0, 15) == 0) begin
                    wait_idle();
                end
            end
            phase++;
        end

        wait_idle();
        if (tracker.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> crc16_frame_validator_unit.f
sv/crc16fv_pkg.sv
sv/crc16fv_cfg_regs.sv
sv/crc16fv_frame_check.sv
sv/crc16_frame_validator_unit.sv
sim/testbench.sv
